// ===== rtl/arm_data_processing_alu_macros.svh =====
// Assertion macros shared by the checker of the data-processing unit.
`ifndef ARM_DATA_PROCESSING_ALU_MACROS_SVH
`define ARM_DATA_PROCESSING_ALU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpalu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dpalu assertion failed");

`endif

// ===== rtl/dpalu_pkg.sv =====
// Package of the data-processing unit: opcodes, operation codes and the command type.
`default_nettype none
package dpalu_pkg;

	// Field widths
	localparam int REG_IDX_W = 4;
	localparam int DATA_W    = 32;

	// Instruction opcodes
	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;

	// Bit positions in the flag register
	localparam int FLAG_N = 2;
	localparam int FLAG_Z = 1;
	localparam int FLAG_C = 0;

	// Operation performed by the execute unit
	typedef enum logic [2:0] {
		FN_AND,
		FN_EOR,
		FN_SUB,
		FN_RSB,
		FN_ADD,
		FN_ORR,
		FN_MOV
	} alu_fn_t;

	// Classified instruction handed from the front to the back
	typedef struct packed {
		logic                 unsup;
		logic                 writes;
		logic                 has_c;
		alu_fn_t              fn;
		logic [REG_IDX_W-1:0] first_reg;
		logic [REG_IDX_W-1:0] dest_reg;
		logic                 set_flags;
		logic [DATA_W-1:0]    operand_two;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dpalu_front.sv =====
// Front end: unpacks incoming items and classifies the opcode into a command.
`default_nettype none
module dpalu_front (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [47:0]     s_tdata,
	input  wire logic [3:0]      s_tuser,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output dpalu_pkg::cmd_t      push_cmd
);
	import dpalu_pkg::*;

	// Pass the handshake straight into the queue
	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

	// Classify the opcode
	always_comb begin
		push_cmd.unsup       = 1'b0;
		push_cmd.writes      = 1'b0;
		push_cmd.has_c       = 1'b0;
		push_cmd.fn          = FN_MOV;
		push_cmd.first_reg   = s_tdata[3:0];
		push_cmd.dest_reg    = s_tdata[7:4];
		push_cmd.set_flags   = s_tdata[8];
		push_cmd.operand_two = s_tdata[40:9];
		unique case (s_tuser)
			OP_AND: begin
				push_cmd.fn     = FN_AND;
				push_cmd.writes = 1'b1;
			end
			OP_EOR: begin
				push_cmd.fn     = FN_EOR;
				push_cmd.writes = 1'b1;
			end
			OP_SUB: begin
				push_cmd.fn     = FN_SUB;
				push_cmd.writes = 1'b1;
				push_cmd.has_c  = 1'b1;
			end
			OP_RSB: begin
				push_cmd.fn     = FN_RSB;
				push_cmd.writes = 1'b1;
				push_cmd.has_c  = 1'b1;
			end
			OP_ADD: begin
				push_cmd.fn     = FN_ADD;
				push_cmd.writes = 1'b1;
				push_cmd.has_c  = 1'b1;
			end
			OP_TST: begin
				push_cmd.fn = FN_AND;
			end
			OP_TEQ: begin
				push_cmd.fn = FN_EOR;
			end
			OP_CMP: begin
				push_cmd.fn    = FN_SUB;
				push_cmd.has_c = 1'b1;
			end
			OP_ORR: begin
				push_cmd.fn     = FN_ORR;
				push_cmd.writes = 1'b1;
			end
			OP_MOV: begin
				push_cmd.fn     = FN_MOV;
				push_cmd.writes = 1'b1;
			end
			default: begin
				push_cmd.unsup = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/dpalu_queue.sv =====
// Two-entry command queue between the front end and the execute unit.
`default_nettype none
module dpalu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire dpalu_pkg::cmd_t push_cmd,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output dpalu_pkg::cmd_t      pop_cmd
);
	import dpalu_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dpalu_back.sv =====
// Execute unit: register file, flag register, adder and logic unit, result register.
`default_nettype none
module dpalu_back #(
	parameter int REG_COUNT = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	input  wire dpalu_pkg::cmd_t pop_cmd,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [39:0]          m_tdata,
	output logic [0:0]           m_tuser
);
	import dpalu_pkg::*;

	localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int EXT_W = (IDX_W > REG_IDX_W) ? IDX_W : REG_IDX_W;

	logic [DATA_W-1:0] regs_q [REG_COUNT];
	logic [2:0]        flags_q;
	logic              out_valid_q;
	logic [39:0]       out_data_q;
	logic              out_unsup_q;

	logic [EXT_W-1:0]  rn_ext;
	logic [EXT_W-1:0]  rd_ext;
	logic              rn_ok;
	logic              rd_ok;
	logic [DATA_W-1:0] op_a;
	logic [DATA_W-1:0] op_b;
	logic [DATA_W-1:0] add_x;
	logic [DATA_W-1:0] add_y;
	logic              add_cin;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] res;
	logic              written;
	logic [2:0]        flags_nxt;
	logic              fire;

	// Take the next command whenever the result register is free or draining
	assign pop_ready = !out_valid_q || m_tready;
	assign fire      = pop_valid && pop_ready;

	// Read operand one
	assign rn_ext = EXT_W'(pop_cmd.first_reg);
	assign rd_ext = EXT_W'(pop_cmd.dest_reg);
	assign rn_ok  = (32'(pop_cmd.first_reg) < REG_COUNT);
	assign rd_ok  = (32'(pop_cmd.dest_reg) < REG_COUNT);
	assign op_a   = rn_ok ? regs_q[rn_ext[IDX_W-1:0]] : '0;
	assign op_b   = pop_cmd.operand_two;

	// Shared adder: subtraction adds the inverted operand with carry in
	always_comb begin
		add_x   = op_a;
		add_y   = op_b;
		add_cin = 1'b0;
		case (pop_cmd.fn)
			FN_SUB: begin
				add_y   = ~op_b;
				add_cin = 1'b1;
			end
			FN_RSB: begin
				add_x   = op_b;
				add_y   = ~op_a;
				add_cin = 1'b1;
			end
			default: begin
				add_cin = 1'b0;
			end
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+1)'(add_cin);

	// Select the result
	always_comb begin
		case (pop_cmd.fn)
			FN_AND:  res = op_a & op_b;
			FN_EOR:  res = op_a ^ op_b;
			FN_ORR:  res = op_a | op_b;
			FN_MOV:  res = op_b;
			default: res = sum[DATA_W-1:0];
		endcase
	end

	// Work out write enable and new flags
	assign written = !pop_cmd.unsup && pop_cmd.writes && rd_ok;

	always_comb begin
		flags_nxt = flags_q;
		if (!pop_cmd.unsup && pop_cmd.set_flags) begin
			flags_nxt[FLAG_N] = res[DATA_W-1];
			flags_nxt[FLAG_Z] = (res == '0);
			if (pop_cmd.has_c) begin
				flags_nxt[FLAG_C] = sum[DATA_W];
			end
		end
	end

	// Update register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else if (fire && written) begin
			regs_q[rd_ext[IDX_W-1:0]] <= res;
		end
	end

	// Update flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				flags_q <= flags_nxt;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q[31:0]  <= written ? res : '0;
			out_data_q[32]    <= written;
			out_data_q[36:33] <= written ? pop_cmd.dest_reg : '0;
			out_data_q[37]    <= flags_nxt[FLAG_N];
			out_data_q[38]    <= flags_nxt[FLAG_Z];
			out_data_q[39]    <= flags_nxt[FLAG_C];
			out_unsup_q       <= pop_cmd.unsup;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_unsup_q;

endmodule
`default_nettype wire

// ===== rtl/arm_data_processing_alu.sv =====
// Top level of the data-processing execute unit.
// Executes one decoded data-processing instruction per item against a register file of
// REG_COUNT 32-bit registers and an N/Z/C flag register, and returns one result item per
// input item. Sustained rate is one item per cycle while m_tready stays high: the execute
// unit reads Rn, computes and writes Rd in the same cycle that it takes the command, so
// back-to-back dependent instructions need no stall. An accepted item is first written
// into the command queue; the execute unit works on it as it leaves the queue, and the
// result register presents it. A two-entry queue separates the input side from the
// execute unit, and a result register holds a finished item while the next one is
// accepted. Register file and flags are cleared at once by reset; no clearing pass is
// needed. Unlisted opcodes change nothing and report unsupported in m_tuser.
`default_nettype none
module arm_data_processing_alu #(
	parameter int REG_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// first_reg[3:0], dest_reg[7:4], set_flags[8], operand_two[40:9], zero fill[47:41]
	input  wire logic [47:0] s_tdata,
	// kind[3:0]
	input  wire logic [3:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_value[31:0], result_written[32], written_index[36:33],
	// flag_n[37], flag_z[38], flag_c[39]
	output logic [39:0]      m_tdata,
	// unsupported[0]
	output logic [0:0]       m_tuser
);
	import dpalu_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	dpalu_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	dpalu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dpalu_back #(
		.REG_COUNT (REG_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// ===== rtl/dpalu_checker.sv =====
// Port-level checker of the data-processing unit and its bind to the top level.
`default_nettype none
`include "arm_data_processing_alu_macros.svh"
module dpalu_checker #(
	parameter int REG_COUNT = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [47:0] s_tdata,
	input wire logic [3:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// An unsupported item never writes a register
	`DPALU_ASSERT_IMP(a_unsup_no_write, clk, arst_n, m_tvalid && m_tuser[0], !m_tdata[32])

	// Without a write the value and index read as zero
	`DPALU_ASSERT_IMP(a_nowrite_zero, clk, arst_n, m_tvalid && !m_tdata[32], m_tdata[36:0] == 37'd0)

	// A reported write targets an existing register
	`DPALU_ASSERT_IMP(a_index_range, clk, arst_n, m_tvalid && m_tdata[32], {28'd0, m_tdata[36:33]} < REG_COUNT)

	// A stalled result holds
	`DPALU_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind arm_data_processing_alu dpalu_checker #(.REG_COUNT(REG_COUNT)) u_dpalu_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the data-processing execute unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import dpalu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1450;

	// One expected result item
	typedef struct packed {
		logic [31:0] value;
		logic        written;
		logic [3:0]  index;
		logic        n;
		logic        z;
		logic        c;
		logic        unsup;
	} alu_result_t;

	// Mirror of the register file and flags, with the queue of pending results
	class alu_scoreboard;
		logic [31:0] regs [16];
		logic        flag_n, flag_z, flag_c;
		alu_result_t awaited [$];
		int          mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			flag_n = 1'b0;
			flag_z = 1'b0;
			flag_c = 1'b0;
			mismatches = 0;
		endfunction

		function logic [31:0] reg_value(logic [3:0] idx);
			return regs[idx];
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Execute one accepted instruction and queue its result
		function void note_input(logic [3:0] kind, logic [3:0] rn, logic [3:0] rd, logic s,
				logic [31:0] b);
			logic [31:0] a, r;
			logic        wr, has_c, c, uns;
			alu_result_t e;
			a = regs[rn];
			r = '0;
			wr = 1'b0;
			has_c = 1'b0;
			c = 1'b0;
			uns = 1'b0;
			case (kind)
				OP_AND: begin r = a & b; wr = 1'b1; end
				OP_EOR: begin r = a ^ b; wr = 1'b1; end
				OP_SUB: begin r = a - b; wr = 1'b1; has_c = 1'b1; c = (a >= b); end
				OP_RSB: begin r = b - a; wr = 1'b1; has_c = 1'b1; c = (b >= a); end
				OP_ADD: begin {c, r} = {1'b0, a} + {1'b0, b}; wr = 1'b1; has_c = 1'b1; end
				OP_TST: r = a & b;
				OP_TEQ: r = a ^ b;
				OP_CMP: begin r = a - b; has_c = 1'b1; c = (a >= b); end
				OP_ORR: begin r = a | b; wr = 1'b1; end
				OP_MOV: begin r = b; wr = 1'b1; end
				default: uns = 1'b1;
			endcase
			if (!uns) begin
				if (wr) regs[rd] = r;
				if (s) begin
					flag_n = r[31];
					flag_z = (r == 32'd0);
					if (has_c) flag_c = c;
				end
			end
			e.value   = (wr && !uns) ? r : 32'd0;
			e.written = wr && !uns;
			e.index   = (wr && !uns) ? rd : 4'd0;
			e.n       = flag_n;
			e.z       = flag_z;
			e.c       = flag_c;
			e.unsup   = uns;
			awaited.push_back(e);
		endfunction

		// Compare one accepted result against the oldest expectation
		function void check_result(logic [39:0] data, logic [0:0] user);
			alu_result_t e, got;
			got.value   = data[31:0];
			got.written = data[32];
			got.index   = data[36:33];
			got.n       = data[37];
			got.z       = data[38];
			got.c       = data[39];
			got.unsup   = user[0];
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: value=%h wr=%b idx=%0d nzc=%b%b%b unsup=%b",
						got.value, got.written, got.index, got.n, got.z, got.c, got.unsup);
				return;
			end
			e = awaited.pop_front();
			if (got.value !== e.value || got.written !== e.written || got.index !== e.index ||
					got.n !== e.n || got.z !== e.z || got.c !== e.c || got.unsup !== e.unsup) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: value=%h wr=%b idx=%0d nzc=%b%b%b unsup=%b",
						e.value, e.written, e.index, e.n, e.z, e.c, e.unsup);
					$display("         got: value=%h wr=%b idx=%0d nzc=%b%b%b unsup=%b",
						got.value, got.written, got.index, got.n, got.z, got.c, got.unsup);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	alu_scoreboard alu_sb;
	bit            no_idle;
	int            cycles;

	arm_data_processing_alu #(.REG_COUNT(16)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watch both handshakes: note accepted items, then check accepted results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			alu_sb.note_input(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[8], s_tdata[40:9]);
		if (arst_n && m_tvalid && m_tready)
			alu_sb.check_result(m_tdata, m_tuser);
	end

	// Stall the result side at random
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= no_idle || ($urandom_range(99) >= 19);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Present one item, with random idle cycles ahead of it, and hold until accepted
	task automatic send_item(input logic [3:0] kind, input logic [3:0] rn, input logic [3:0] rd,
			input logic s, input logic [31:0] b);
		while (!no_idle && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, b, s, rd, rn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Pick an opcode, mostly supported ones
	function automatic logic [3:0] pick_kind();
		logic [3:0] ops [10];
		ops = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};
		if ($urandom_range(99) < 85)
			return ops[$urandom_range(9)];
		return 4'($urandom_range(15));
	endfunction

	// Pick operand two: random, extreme, small, Rn or near -Rn, to hit zero and equal compares
	function automatic logic [31:0] pick_operand(logic [3:0] rn);
		int sel;
		sel = $urandom_range(99);
		if (sel < 55) return $urandom;
		if (sel < 65) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		if (sel < 80) return $urandom_range(3);
		if (sel < 90) return alu_sb.reg_value(rn);
		return ~alu_sb.reg_value(rn) + 32'($urandom_range(2));
	endfunction

	initial begin
		logic [3:0] rn;
		alu_sb   = new();
		cycles   = 0;
		no_idle  = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every opcode, carries, borrows, no-flag test ops, unlisted opcodes
		send_item(OP_MOV, 4'd0, 4'd0, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_MOV, 4'd0, 4'd1, 1'b1, 32'h0000_0000);
		send_item(OP_MOV, 4'd0, 4'd2, 1'b0, 32'h8000_0000);
		send_item(OP_MOV, 4'd0, 4'd15, 1'b1, 32'h7FFF_FFFF);
		send_item(OP_ADD, 4'd0, 4'd3, 1'b1, 32'd1);
		send_item(OP_ADD, 4'd15, 4'd4, 1'b1, 32'd1);
		send_item(OP_SUB, 4'd1, 4'd5, 1'b1, 32'd1);
		send_item(OP_SUB, 4'd0, 4'd6, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_RSB, 4'd0, 4'd7, 1'b1, 32'd0);
		send_item(OP_RSB, 4'd1, 4'd8, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_AND, 4'd0, 4'd9, 1'b1, 32'hA5A5_A5A5);
		send_item(OP_EOR, 4'd0, 4'd10, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_ORR, 4'd2, 4'd11, 1'b1, 32'd1);
		send_item(OP_TST, 4'd0, 4'd12, 1'b1, 32'h8000_0000);
		send_item(OP_TEQ, 4'd0, 4'd13, 1'b1, 32'hFFFF_FFFF);
		send_item(OP_CMP, 4'd1, 4'd14, 1'b1, 32'd0);
		send_item(OP_CMP, 4'd1, 4'd14, 1'b1, 32'd1);
		send_item(OP_TST, 4'd0, 4'd3, 1'b0, 32'h0000_0000);
		send_item(OP_CMP, 4'd15, 4'd3, 1'b0, 32'hFFFF_FFFF);
		send_item(4'd5, 4'd0, 4'd15, 1'b1, 32'h0000_0000);
		send_item(4'd6, 4'd1, 4'd7, 1'b1, 32'hFFFF_FFFF);
		send_item(4'd7, 4'd2, 4'd3, 1'b0, 32'h1234_5678);
		send_item(4'd11, 4'd3, 4'd0, 1'b1, 32'd1);
		send_item(4'd14, 4'd4, 4'd1, 1'b1, 32'h8000_0000);
		send_item(4'd15, 4'd15, 4'd15, 1'b1, 32'h0000_0000);

		// Random instruction stream, with one stretch free of idling on both sides
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 500 && i < 800);
			rn = 4'($urandom_range(15));
			send_item(pick_kind(), rn, 4'($urandom_range(15)), 1'($urandom_range(1)),
				pick_operand(rn));
		end
		no_idle = 1'b0;
		s_tvalid <= 1'b0;

		// Drain, then keep watching for stray results before the verdict
		while (alu_sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (alu_sb.mismatches == 0 && alu_sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/dpalu_pkg.sv
rtl/dpalu_front.sv
rtl/dpalu_queue.sv
rtl/dpalu_back.sv
rtl/arm_data_processing_alu.sv
rtl/dpalu_checker.sv
tb/tb_top.sv
